FILE: src/deq_pkg.sv
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue with search.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int CMD_W     = 3;
  localparam int VAL_W     = 32;
  localparam int STAT_W    = 2;
  localparam int POS_W     = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_SEARCH     = 3'd4,
    CMD_SHOW       = 3'd5
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_t;

  // What every cell of the row does at each clock edge
  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LEFT  = 2'd1,  // take the neighbor toward the back, last cell wraps to cell 0
    CELL_RIGHT = 2'd2,  // take the neighbor toward the front, cell 0 takes din
    CELL_WRITE = 2'd3   // only the addressed cell takes din
  } cell_op_t;

  typedef struct packed {
    cell_op_t          op;
    logic [VAL_W-1:0]  din;
  } cell_ctrl_t;

  typedef enum logic {
    CTRL_IDLE = 1'b0,
    CTRL_WALK = 1'b1
  } ctrl_state_t;

endpackage

FILE: src/deq_cell.sv
// ----------------------------------------------------------------------------
// deq_cell
// One storage cell of the queue row: holds one entry and trades it with its
// neighbors under a command shared by the whole row.
// ----------------------------------------------------------------------------
module deq_cell #(
  parameter int INDEX  = 0,
  parameter int ADDR_W = 4
) (
  input  logic                      clk,
  input  deq_pkg::cell_ctrl_t       ctl,
  input  logic [ADDR_W-1:0]         wr_addr,
  input  logic [deq_pkg::VAL_W-1:0] from_left,
  input  logic [deq_pkg::VAL_W-1:0] from_right,
  output logic [deq_pkg::VAL_W-1:0] value
);
  import deq_pkg::*;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      CELL_HOLD:  value <= value;
      CELL_LEFT:  value <= from_right;
      CELL_RIGHT: value <= from_left;
      CELL_WRITE: begin
        if (wr_addr == ADDR_W'(INDEX)) begin
          value <= ctl.din;
        end
      end
      default:    value <= value;
    endcase
  end

endmodule

FILE: src/deq_chain.sv
// ----------------------------------------------------------------------------
// deq_chain
// Row of DEPTH cells closed into a ring. Cell 0 holds the front entry and
// cell i the entry at position i from the front.
// ----------------------------------------------------------------------------
module deq_chain #(
  parameter int DEPTH  = deq_pkg::DEPTH_DEF,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  deq_pkg::cell_ctrl_t       ctl,
  input  logic [ADDR_W-1:0]         wr_addr,
  output logic [deq_pkg::VAL_W-1:0] head
);
  import deq_pkg::*;

  logic [VAL_W-1:0] vals [DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VAL_W-1:0] left_val;
    logic [VAL_W-1:0] right_val;

    if (i == 0) begin : g_first
      assign left_val = ctl.din;
    end else begin : g_mid_l
      assign left_val = vals[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_val = vals[0];
    end else begin : g_mid_r
      assign right_val = vals[i+1];
    end

    deq_cell #(
      .INDEX  (i),
      .ADDR_W (ADDR_W)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .wr_addr    (wr_addr),
      .from_left  (left_val),
      .from_right (right_val),
      .value      (vals[i])
    );
  end

  assign head = vals[0];

endmodule

FILE: src/deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// deque_with_search_unit
// Bounded double-ended queue of signed 32-bit words with search and show.
// ----------------------------------------------------------------------------
// Entries sit in a row of DEPTH cells, front in cell 0. Push front, push back
// and pop front each return one word. Pop back, search and show rotate the
// whole ring once past cell 0, one cell per cycle while the output is not
// stalled; show emits one word per entry, front to back, with tlast on the
// final one. A command on an empty queue (or a push on a full one) answers
// with a status word and no walk. Codes 6 and 7 are consumed without a
// result. A result word that waits in the output register holds off the input,
// and so does a walk; in idle the next command is taken in the cycle that the
// waiting word is taken.
// ----------------------------------------------------------------------------
module deque_with_search_unit #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value_in
  input  logic [2:0]  s_tuser,   // [2:0] command
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] value_out, [36:32] position, [37] found
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast    // last_result
);
  import deq_pkg::*;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam logic [ADDR_W-1:0] LAST_STEP = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);

  ctrl_state_t       state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] step, step_next;
  cmd_t              cmd_lat, cmd_lat_next;
  logic [VAL_W-1:0]  key, key_next;
  logic              hit, hit_next;
  logic [POS_W-1:0]  hit_pos, hit_pos_next;

  cell_ctrl_t        ctl;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  head;

  logic              out_free;
  logic              load_out;
  status_t           o_status;
  logic [VAL_W-1:0]  o_value;
  logic [POS_W-1:0]  o_pos;
  logic              o_found;
  logic              o_last;

  cmd_t              cmd_in;
  logic [CNT_W-1:0]  step_wide;
  logic [CNT_W-1:0]  step_plus;
  logic              in_range;
  logic              at_back;
  logic              match;

  deq_chain #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_chain (
    .clk     (clk),
    .ctl     (ctl),
    .wr_addr (wr_addr),
    .head    (head)
  );

  assign out_free  = !m_tvalid || m_tready;
  assign cmd_in    = cmd_t'(s_tuser);
  assign step_wide = CNT_W'(step);
  assign step_plus = step_wide + CNT_W'(1);
  assign in_range  = step_wide < count;
  assign at_back   = step_plus == count;
  assign match     = in_range && (head == key);
  assign wr_addr   = count[ADDR_W-1:0];

  always_comb begin
    state_next   = state;
    count_next   = count;
    step_next    = step;
    cmd_lat_next = cmd_lat;
    key_next     = key;
    hit_next     = hit;
    hit_pos_next = hit_pos;
    ctl.op       = CELL_HOLD;
    ctl.din      = s_tdata;
    load_out     = 1'b0;
    o_status     = STAT_OK;
    o_value      = '0;
    o_pos        = '0;
    o_found      = 1'b0;
    o_last       = 1'b1;
    s_tready     = 1'b0;

    unique case (state)
      CTRL_IDLE: begin
        s_tready = out_free;
        if (s_tvalid && out_free) begin
          unique case (cmd_in)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
              load_out = 1'b1;
              if (count == FULL_CNT) begin
                o_status = STAT_FULL;
              end else begin
                ctl.op     = (cmd_in == CMD_PUSH_FRONT) ? CELL_RIGHT : CELL_WRITE;
                count_next = count + CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              load_out = 1'b1;
              if (count == '0) begin
                o_status = STAT_EMPTY;
              end else begin
                o_value    = head;
                ctl.op     = CELL_LEFT;
                count_next = count - CNT_W'(1);
              end
            end
            CMD_POP_BACK, CMD_SEARCH, CMD_SHOW: begin
              if (count == '0) begin
                load_out = 1'b1;
                o_status = STAT_EMPTY;
              end else begin
                state_next   = CTRL_WALK;
                step_next    = '0;
                cmd_lat_next = cmd_in;
                key_next     = s_tdata;
                hit_next     = 1'b0;
                hit_pos_next = '0;
              end
            end
            default: begin
              // unused code: drop the word
            end
          endcase
        end
      end
      CTRL_WALK: begin
        if (out_free) begin
          // advance the ring one cell; a full turn restores the order
          ctl.op    = CELL_LEFT;
          step_next = step + ADDR_W'(1);
          unique case (cmd_lat)
            CMD_SHOW: begin
              if (in_range) begin
                load_out = 1'b1;
                o_value  = head;
                o_last   = at_back;
              end
            end
            CMD_POP_BACK: begin
              if (at_back) begin
                load_out = 1'b1;
                o_value  = head;
              end
            end
            CMD_SEARCH: begin
              if (match && !hit) begin
                hit_next     = 1'b1;
                hit_pos_next = POS_W'(step_plus);
              end
              if (step == LAST_STEP) begin
                load_out = 1'b1;
                o_found  = hit || match;
                o_pos    = hit ? hit_pos : (match ? POS_W'(step_plus) : '0);
              end
            end
            default: begin
            end
          endcase
          if (step == LAST_STEP) begin
            state_next = CTRL_IDLE;
            if (cmd_lat == CMD_POP_BACK) begin
              count_next = count - CNT_W'(1);
            end
          end
        end
      end
      default: state_next = CTRL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= CTRL_IDLE;
      count    <= '0;
      step     <= '0;
      hit      <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      step  <= step_next;
      hit   <= hit_next;
      if (load_out) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_lat <= cmd_lat_next;
    key     <= key_next;
    hit_pos <= hit_pos_next;
    if (load_out) begin
      m_tdata <= {2'b00, o_found, o_pos, o_value};
      m_tuser <= o_status;
      m_tlast <= o_last;
    end
  end

endmodule

FILE: tb/tb_deque_with_search_unit.sv
// ----------------------------------------------------------------------------
// tb_deque_with_search_unit
// Self-checking bench for the double-ended queue with search and show.
// ----------------------------------------------------------------------------
// The bench keeps a shadow ring that it updates on every accepted command.
// Each accepted command adds its expected result words to a queue. Each
// result word that leaves the block is compared field by field with the
// oldest entry in that queue. Both handshake sides idle in random bursts.
// One phase holds the output off long enough to back up the input. The
// final phase runs at full rate.
// ----------------------------------------------------------------------------
module tb_deque_with_search_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import deq_pkg::*;

  localparam int QDEPTH      = DEPTH_DEF;
  localparam int SINK_HOLD   = 200;
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_TAIL  = 2 * QDEPTH + 8;

  // Codes the block consumes without answering
  localparam logic [CMD_W-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD7 = 3'd7;

  typedef struct packed {
    status_t          status;
    logic [VAL_W-1:0] value;
    logic [POS_W-1:0] position;
    logic             found;
    logic             last;
  } deq_result_t;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;   // [31:0] value_in
  logic [2:0]  s_tuser  = '0;   // [2:0] command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;         // [31:0] value_out, [36:32] position, [37] found
  logic [1:0]  m_tuser;         // [1:0] status
  logic        m_tlast;         // last_result

  // Shadow ring of the queue contents
  logic [VAL_W-1:0] ring_mem [QDEPTH];
  int               head = 0;
  int               fill = 0;

  deq_result_t pending_results[$];
  deq_result_t want;
  int          errors       = 0;
  int          quiet_cycles = 0;

  int src_idle_pct   = 0;
  int sink_stall_pct = 0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int stall_left     = 0;

  deque_with_search_unit #(.DEPTH(QDEPTH)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always #5 clk = ~clk;

  // Apply one command to the shadow ring and queue its result words
  function automatic void deque_apply(input logic [CMD_W-1:0] cmd,
                                      input logic [VAL_W-1:0] val);
    deq_result_t r;
    int          k;
    r = '0;
    r.status = STAT_OK;
    r.last   = 1'b1;
    case (cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (fill >= QDEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            head = (head + QDEPTH - 1) % QDEPTH;
            ring_mem[head] = val;
          end else begin
            ring_mem[(head + fill) % QDEPTH] = val;
          end
          fill++;
        end
        pending_results.push_back(r);
      end
      CMD_POP_FRONT, CMD_POP_BACK: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else if (cmd == CMD_POP_FRONT) begin
          r.value = ring_mem[head];
          head = (head + 1) % QDEPTH;
          fill--;
        end else begin
          r.value = ring_mem[(head + fill - 1) % QDEPTH];
          fill--;
        end
        pending_results.push_back(r);
      end
      CMD_SEARCH: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          for (k = 0; k < fill; k++) begin
            if (!r.found && ring_mem[(head + k) % QDEPTH] == val) begin
              r.found    = 1'b1;
              r.position = POS_W'(k + 1);
            end
          end
        end
        pending_results.push_back(r);
      end
      CMD_SHOW: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (k = 0; k < fill; k++) begin
            r.value = ring_mem[(head + k) % QDEPTH];
            r.last  = (k == fill - 1);
            pending_results.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Predict on every accepted input word
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      deque_apply(s_tuser, s_tdata);
  end

  task automatic check_field(input string what, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, exp_v, got_v);
      errors++;
    end
  endtask

  // Compare every accepted result word with the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got tdata %0h tuser %0h tlast %0b",
                 $time, m_tdata, m_tuser, m_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(m_tuser));
        check_field("value_out", want.value, m_tdata[31:0]);
        check_field("position", 32'(want.position), 32'(m_tdata[36:32]));
        check_field("found", 32'(want.found), 32'(m_tdata[37]));
        check_field("last_result", 32'(want.last), 32'(m_tlast));
      end
    end
  end

  // Output side: random stall bursts, plus a long hold on request
  always @(posedge clk) begin
    if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = SINK_HOLD;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(99) < sink_stall_pct) begin
      stall_left = $urandom_range(16, 1) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no handshake for %0d cycles, %0d results outstanding",
               $time, QUIET_LIMIT, pending_results.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Offer one word and hold it until accepted; called at a rising edge
  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [VAL_W-1:0] val);
    int gap;
    if ($urandom_range(99) < src_idle_pct) begin
      gap = $urandom_range(16, 1);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= val;
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop offering and wait until every expected word has come out
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(19))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  // Mostly a value that is stored, so searches hit at every position
  function automatic logic [VAL_W-1:0] search_value();
    if (fill > 0 && $urandom_range(99) < 65)
      return ring_mem[(head + $urandom_range(fill - 1)) % QDEPTH];
    return rand_value();
  endfunction

  // Random command; push_pct steers the fill level
  task automatic send_random(input int push_pct, output bit counted);
    logic [CMD_W-1:0] cmd;
    int               r;
    counted = 1'b1;
    r = $urandom_range(99);
    if (r < push_pct) begin
      cmd = $urandom_range(1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
    end else begin
      r = $urandom_range(99);
      if (r < 48)      cmd = $urandom_range(1) ? CMD_POP_FRONT : CMD_POP_BACK;
      else if (r < 75) cmd = CMD_SEARCH;
      else if (r < 95) cmd = CMD_SHOW;
      else begin
        cmd = $urandom_range(1) ? CMD_RSVD6 : CMD_RSVD7;
        counted = 1'b0;
      end
    end
    send_word(cmd, (cmd == CMD_SEARCH) ? search_value() : rand_value());
  endtask

  task automatic test_empty_queue();
    src_idle_pct   = 20;
    sink_stall_pct = 20;
    send_word(CMD_POP_FRONT, 32'h0);
    send_word(CMD_POP_BACK, 32'hFFFF_FFFF);
    send_word(CMD_SEARCH, 32'h0);
    send_word(CMD_SHOW, 32'h0);
    send_word(CMD_RSVD6, 32'h1234_5678);
    send_word(CMD_RSVD7, 32'hFFFF_FFFF);
  endtask

  task automatic test_push_pop_search();
    send_word(CMD_PUSH_FRONT, 32'h7FFF_FFFF);
    send_word(CMD_PUSH_BACK, 32'h8000_0000);
    send_word(CMD_PUSH_FRONT, 32'h0000_0000);
    send_word(CMD_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(CMD_SHOW, 32'h0);
    send_word(CMD_SEARCH, 32'h0000_0000);   // match at the front
    send_word(CMD_SEARCH, 32'hFFFF_FFFF);   // match at the back
    send_word(CMD_SEARCH, 32'h5A5A_A5A5);   // no match
    send_word(CMD_POP_BACK, 32'h0);
    send_word(CMD_POP_FRONT, 32'h0);
    send_word(CMD_SHOW, 32'h0);
  endtask

  task automatic test_full_queue();
    logic [VAL_W-1:0] back_val;
    int               n;
    wait_drained();
    n = QDEPTH - fill;
    back_val = '0;
    repeat (n) begin
      back_val = rand_value();
      send_word(CMD_PUSH_BACK, back_val);
    end
    send_word(CMD_PUSH_FRONT, rand_value());
    send_word(CMD_PUSH_BACK, rand_value());
    send_word(CMD_SHOW, 32'h0);
    send_word(CMD_SEARCH, back_val);
    send_word(CMD_POP_FRONT, 32'h0);
    send_word(CMD_PUSH_BACK, rand_value());
    send_word(CMD_POP_BACK, 32'h0);
  endtask

  task automatic test_random_mix();
    int seg;
    int done;
    int push_pct;
    bit counted;
    for (seg = 0; seg < 4; seg++) begin
      push_pct       = $urandom_range(80, 20);
      src_idle_pct   = $urandom_range(1) * 30;
      sink_stall_pct = $urandom_range(1) * 30;
      done = 0;
      while (done < 20) begin
        send_random(push_pct, counted);
        if (counted) done++;
      end
    end
  endtask

  // Hold the output off while random commands, mostly pushes, keep coming, then drain
  task automatic test_backpressure();
    bit counted;
    int done;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    hold_req       = 1'b1;
    done = 0;
    while (done < 25) begin
      send_random(60, counted);
      if (counted) done++;
    end
    wait_drained();
  endtask

  task automatic test_streaming();
    bit counted;
    int done;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    done = 0;
    while (done < 20) begin
      send_random(50, counted);
      if (counted) done++;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_empty_queue();
    test_push_pop_search();
    test_full_queue();
    test_random_mix();
    test_backpressure();
    test_streaming();
    wait_drained();
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

FILE: sim.f
src/deq_pkg.sv
src/deq_cell.sv
src/deq_chain.sv
src/deque_with_search_unit.sv
tb/tb_deque_with_search_unit.sv
